FILE: rtl/mgpa_pkg.sv
// Shared constants, register codes and the configuration struct for the motion grid alarm.
package mgpa_pkg;

    localparam int GRID_SPLIT_DEF = 10;

    localparam int ROW_W    = 4;
    localparam int COL_W    = 4;
    localparam int MOTION_W = 21;
    localparam int LEVEL_W  = 17;
    localparam int COUNT_W  = 16;
    localparam int DIM_W    = 11;
    localparam int HIST_W   = 7;
    localparam int BOUND_W  = 11;
    localparam int THR_W    = 15;
    localparam int CENTER_W = 16;
    localparam int ENTRY_W  = LEVEL_W + COUNT_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 3'd7;

    localparam logic [DIM_W-1:0]   RST_CELL_W     = 11'd80;
    localparam logic [DIM_W-1:0]   RST_CELL_H     = 11'd60;
    localparam logic [HIST_W-1:0]  RST_HISTORY    = 7'd5;
    localparam logic [COUNT_W-1:0] RST_DURATION   = 16'd36;
    localparam logic [BOUND_W-1:0] RST_LEFT       = 11'd0;
    localparam logic [BOUND_W-1:0] RST_RIGHT      = 11'd800;
    localparam logic [BOUND_W-1:0] RST_UPPER      = 11'd0;
    localparam logic [BOUND_W-1:0] RST_LOWER      = 11'd600;
    localparam logic [LEVEL_W-1:0] RST_CAP        = 17'd400;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [DIM_W-1:0]   cell_w;
        logic [DIM_W-1:0]   cell_h;
        logic [COUNT_W-1:0] duration;
        logic [BOUND_W-1:0] left_bound;
        logic [BOUND_W-1:0] right_bound;
        logic [BOUND_W-1:0] upper_bound;
        logic [BOUND_W-1:0] lower_bound;
        logic [LEVEL_W-1:0] cap;
        logic [THR_W-1:0]   thr;
    } t_cfg;

endpackage

FILE: rtl/mgpa_cfg.sv
// Configuration register file with registered level cap and threshold.
module mgpa_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mgpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mgpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mgpa_pkg::t_cfg                      o_cfg
);

    logic [mgpa_pkg::DIM_W-1:0]   r_cell_w;
    logic [mgpa_pkg::DIM_W-1:0]   r_cell_h;
    logic [mgpa_pkg::HIST_W-1:0]  r_history;
    logic [mgpa_pkg::COUNT_W-1:0] r_duration;
    logic [mgpa_pkg::BOUND_W-1:0] r_left;
    logic [mgpa_pkg::BOUND_W-1:0] r_right;
    logic [mgpa_pkg::BOUND_W-1:0] r_upper;
    logic [mgpa_pkg::BOUND_W-1:0] r_lower;
    logic [mgpa_pkg::LEVEL_W-1:0] r_cap;
    logic [mgpa_pkg::LEVEL_W-1:0] n_cap;
    logic [mgpa_pkg::DIM_W+mgpa_pkg::HIST_W-1:0] prod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w   <= mgpa_pkg::RST_CELL_W;
            r_cell_h   <= mgpa_pkg::RST_CELL_H;
            r_history  <= mgpa_pkg::RST_HISTORY;
            r_duration <= mgpa_pkg::RST_DURATION;
            r_left     <= mgpa_pkg::RST_LEFT;
            r_right    <= mgpa_pkg::RST_RIGHT;
            r_upper    <= mgpa_pkg::RST_UPPER;
            r_lower    <= mgpa_pkg::RST_LOWER;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mgpa_pkg::REG_CELL_W:   r_cell_w   <= i_cfg_data[mgpa_pkg::DIM_W-1:0];
                mgpa_pkg::REG_CELL_H:   r_cell_h   <= i_cfg_data[mgpa_pkg::DIM_W-1:0];
                mgpa_pkg::REG_HISTORY:  r_history  <= i_cfg_data[mgpa_pkg::HIST_W-1:0];
                mgpa_pkg::REG_DURATION: r_duration <= i_cfg_data[mgpa_pkg::COUNT_W-1:0];
                mgpa_pkg::REG_LEFT:     r_left     <= i_cfg_data[mgpa_pkg::BOUND_W-1:0];
                mgpa_pkg::REG_RIGHT:    r_right    <= i_cfg_data[mgpa_pkg::BOUND_W-1:0];
                mgpa_pkg::REG_UPPER:    r_upper    <= i_cfg_data[mgpa_pkg::BOUND_W-1:0];
                mgpa_pkg::REG_LOWER:    r_lower    <= i_cfg_data[mgpa_pkg::BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // cap = cell width * history, saturated to the level width
    assign prod = (mgpa_pkg::DIM_W+mgpa_pkg::HIST_W)'(r_cell_w)
                * (mgpa_pkg::DIM_W+mgpa_pkg::HIST_W)'(r_history);

    always_comb begin
        if (prod > (mgpa_pkg::DIM_W+mgpa_pkg::HIST_W)'(mgpa_pkg::LEVEL_MAX)) begin
            n_cap = mgpa_pkg::LEVEL_MAX;
        end else begin
            n_cap = prod[mgpa_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= mgpa_pkg::RST_CAP;
        end else begin
            r_cap <= n_cap;
        end
    end

    assign o_cfg.cell_w      = r_cell_w;
    assign o_cfg.cell_h      = r_cell_h;
    assign o_cfg.duration    = r_duration;
    assign o_cfg.left_bound  = r_left;
    assign o_cfg.right_bound = r_right;
    assign o_cfg.upper_bound = r_upper;
    assign o_cfg.lower_bound = r_lower;
    assign o_cfg.cap         = r_cap;
    assign o_cfg.thr         = r_cap[mgpa_pkg::LEVEL_W-1:2];

endmodule

FILE: rtl/mgpa_mem.sv
// Cell state memory: level and counter per cell, valid bits, read-after-write forwarding.
module mgpa_mem #(
    parameter int DEPTH = mgpa_pkg::GRID_SPLIT_DEF * mgpa_pkg::GRID_SPLIT_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_re,
    input  logic [AW-1:0]                   i_raddr,
    output logic [mgpa_pkg::ENTRY_W-1:0]    o_rdata,
    input  logic                            i_we,
    input  logic [AW-1:0]                   i_waddr,
    input  logic [mgpa_pkg::ENTRY_W-1:0]    i_wdata
);

    logic [mgpa_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]             r_valid;
    logic [mgpa_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else if (r_valid[i_raddr]) begin
                r_rdata <= mem[i_raddr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/motion_grid_persistence_alarm.sv
// Top level: per-cell leaky level and persistence counter with windowed frame alarm.
// Pipeline: stage 1 (memory read and update), then the output register.
// Throughput: one cell per cycle while the output register is not held by a stall; a state
//   write forwards into a same-cycle read of that cell.
// Reset (synchronous, active low): control and configuration registers return to defaults,
//   per-cell valid bits clear at once so every cell reads as level 0, count 0.
module motion_grid_persistence_alarm #(
    parameter int GRID_SPLIT = mgpa_pkg::GRID_SPLIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mgpa_pkg::ROW_W-1:0]          i_cell_row,
    input  logic [mgpa_pkg::COL_W-1:0]          i_cell_col,
    input  logic [mgpa_pkg::MOTION_W-1:0]       i_motion_count,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mgpa_pkg::LEVEL_W-1:0]        o_cell_level,
    output logic [mgpa_pkg::COUNT_W-1:0]        o_cell_count,
    output logic                                o_in_window,
    output logic                                o_cell_alarm,
    output logic                                o_frame_alarm,
    output logic                                o_last_cell,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mgpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mgpa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CELLS = GRID_SPLIT * GRID_SPLIT;
    localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    mgpa_pkg::t_cfg cfg;

    mgpa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic in_xfer;
    logic out_free;
    logic adv;       // stage 1 moves into the output register

    assign out_free   = !o_out_valid || !i_out_stall;
    assign adv        = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // ---------------- stage 0: index, range, cell center ----------------
    logic                             s0_inr;
    logic                             s0_last;
    logic [IW-1:0]                    s0_idx;
    logic [mgpa_pkg::CENTER_W-1:0]    s0_cx;
    logic [mgpa_pkg::CENTER_W-1:0]    s0_cy;

    assign s0_inr  = ({1'b0, i_cell_row} < (mgpa_pkg::ROW_W+1)'(GRID_SPLIT))
                  && ({1'b0, i_cell_col} < (mgpa_pkg::COL_W+1)'(GRID_SPLIT));
    assign s0_last = (i_cell_row == mgpa_pkg::ROW_W'(GRID_SPLIT - 1))
                  && (i_cell_col == mgpa_pkg::COL_W'(GRID_SPLIT - 1));
    assign s0_idx  = IW'(int'(i_cell_row) * GRID_SPLIT + int'(i_cell_col));

    // center = index * size + size / 2
    assign s0_cx = mgpa_pkg::CENTER_W'(i_cell_col) * mgpa_pkg::CENTER_W'(cfg.cell_w)
                 + mgpa_pkg::CENTER_W'(cfg.cell_w >> 1);
    assign s0_cy = mgpa_pkg::CENTER_W'(i_cell_row) * mgpa_pkg::CENTER_W'(cfg.cell_h)
                 + mgpa_pkg::CENTER_W'(cfg.cell_h >> 1);

    logic                             r_s1_inr;
    logic                             r_s1_last;
    logic [IW-1:0]                    r_s1_idx;
    logic [mgpa_pkg::MOTION_W-1:0]    r_s1_motion;
    logic [mgpa_pkg::CENTER_W-1:0]    r_s1_cx;
    logic [mgpa_pkg::CENTER_W-1:0]    r_s1_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_inr    <= s0_inr;
            r_s1_last   <= s0_last;
            r_s1_idx    <= s0_idx;
            r_s1_motion <= i_motion_count;
            r_s1_cx     <= s0_cx;
            r_s1_cy     <= s0_cy;
        end
    end

    // ---------------- cell state memory ----------------
    logic [mgpa_pkg::ENTRY_W-1:0] rd_entry;
    logic [mgpa_pkg::ENTRY_W-1:0] wr_entry;
    logic                         mem_we;

    assign mem_we = adv && r_s1_inr;

    mgpa_mem #(
        .DEPTH (CELLS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (in_xfer && s0_inr),
        .i_raddr (s0_idx),
        .o_rdata (rd_entry),
        .i_we    (mem_we),
        .i_waddr (r_s1_idx),
        .i_wdata (wr_entry)
    );

    // ---------------- stage 1: update ----------------
    logic [mgpa_pkg::LEVEL_W-1:0]    old_lvl;
    logic [mgpa_pkg::COUNT_W-1:0]    old_cnt;
    logic [mgpa_pkg::MOTION_W:0]     lvl_sum;
    logic [mgpa_pkg::LEVEL_W-1:0]    lvl;
    logic [mgpa_pkg::COUNT_W-1:0]    cnt;
    logic [mgpa_pkg::LEVEL_W-1:0]    bw_l;
    logic [mgpa_pkg::LEVEL_W-1:0]    decayed;
    logic                            win;
    logic                            alarm;
    logic                            r_acc;

    assign old_lvl = rd_entry[mgpa_pkg::ENTRY_W-1:mgpa_pkg::COUNT_W];
    assign old_cnt = rd_entry[mgpa_pkg::COUNT_W-1:0];
    assign lvl_sum = (mgpa_pkg::MOTION_W+1)'(old_lvl) + (mgpa_pkg::MOTION_W+1)'(r_s1_motion);

    always_comb begin
        if (lvl_sum > (mgpa_pkg::MOTION_W+1)'(cfg.cap)) begin
            lvl = cfg.cap;
        end else begin
            lvl = lvl_sum[mgpa_pkg::LEVEL_W-1:0];
        end
    end

    // persistence counter: saturating increment while at or above a quarter of the cap, else cleared
    always_comb begin
        if (lvl >= mgpa_pkg::LEVEL_W'(cfg.thr)) begin
            cnt = (old_cnt == mgpa_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
        end else begin
            cnt = '0;
        end
    end

    // leak by one cell width per update of the cell, floor at zero
    assign bw_l    = mgpa_pkg::LEVEL_W'(cfg.cell_w);
    assign decayed = (lvl > bw_l) ? (lvl - bw_l) : '0;
    assign wr_entry = {decayed, cnt};

    assign win = (r_s1_cx >= mgpa_pkg::CENTER_W'(cfg.left_bound))
              && (r_s1_cx <= mgpa_pkg::CENTER_W'(cfg.right_bound))
              && (r_s1_cy >= mgpa_pkg::CENTER_W'(cfg.upper_bound))
              && (r_s1_cy <= mgpa_pkg::CENTER_W'(cfg.lower_bound));
    assign alarm = win && (cnt >= cfg.duration);

    // frame alarm accumulator, cleared after the last cell's result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 1'b0;
        end else if (adv && r_s1_inr) begin
            r_acc <= r_s1_last ? 1'b0 : (r_acc | alarm);
        end
    end

    // ---------------- output register ----------------
    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s1_inr) begin
                o_cell_level  <= lvl;
                o_cell_count  <= cnt;
                o_in_window   <= win;
                o_cell_alarm  <= alarm;
                o_frame_alarm <= r_acc | alarm;
                o_last_cell   <= r_s1_last;
            end else begin
                // cell off the grid: no update, report the running frame alarm
                o_cell_level  <= '0;
                o_cell_count  <= '0;
                o_in_window   <= 1'b0;
                o_cell_alarm  <= 1'b0;
                o_frame_alarm <= r_acc;
                o_last_cell   <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_valid;

    // ---------------- assertions ----------------
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled with empty update stage");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_inr && r_s1_last) |=> !r_acc)
        else $error("frame alarm not cleared after last cell");

    a_alarm_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_cell_alarm || (o_in_window && o_frame_alarm)))
        else $error("cell alarm without window or frame alarm");

    a_write_only_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_s1_valid && out_free))
        else $error("state written without result transfer");

endmodule

FILE: tb/sv/tb_motion_grid_persistence_alarm.sv
// Self-checking testbench for the motion grid persistence alarm: raster frames under config sweeps.
module tb_motion_grid_persistence_alarm;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID        = mgpa_pkg::GRID_SPLIT_DEF;
    localparam int ITEM_TARGET = 1450;
    localparam int QUIET_LIMIT = 2000;  // cycles with no transfer on any channel
    localparam int SETTLE      = 4;     // two-stage pipeline plus margin
    localparam int LONG_HOLD   = 300;   // receiver back-pressure burst
    localparam logic [mgpa_pkg::MOTION_W-1:0] MOTION_ALL = {mgpa_pkg::MOTION_W{1'b1}};

    // One result transfer, laid out as the output ports.
    typedef struct packed {
        logic [mgpa_pkg::LEVEL_W-1:0] level;
        logic [mgpa_pkg::COUNT_W-1:0] count;
        logic                         in_window;
        logic                         cell_alarm;
        logic                         frame_alarm;
        logic                         last_cell;
    } t_grid_result;

    // Mirrors the per-cell level/count stores and holds the expected result stream.
    class t_grid_alarm_ledger;
        logic [mgpa_pkg::DIM_W-1:0]   cell_w;
        logic [mgpa_pkg::DIM_W-1:0]   cell_h;
        logic [mgpa_pkg::HIST_W-1:0]  history;
        logic [mgpa_pkg::COUNT_W-1:0] duration;
        logic [mgpa_pkg::BOUND_W-1:0] left_bound;
        logic [mgpa_pkg::BOUND_W-1:0] right_bound;
        logic [mgpa_pkg::BOUND_W-1:0] upper_bound;
        logic [mgpa_pkg::BOUND_W-1:0] lower_bound;
        logic [mgpa_pkg::LEVEL_W-1:0] level_mem [GRID*GRID];
        logic [mgpa_pkg::COUNT_W-1:0] count_mem [GRID*GRID];
        logic                         frame_acc;
        t_grid_result                 pending [$];
        int                           errors;

        function new();
            cell_w      = mgpa_pkg::RST_CELL_W;
            cell_h      = mgpa_pkg::RST_CELL_H;
            history     = mgpa_pkg::RST_HISTORY;
            duration    = mgpa_pkg::RST_DURATION;
            left_bound  = mgpa_pkg::RST_LEFT;
            right_bound = mgpa_pkg::RST_RIGHT;
            upper_bound = mgpa_pkg::RST_UPPER;
            lower_bound = mgpa_pkg::RST_LOWER;
            foreach (level_mem[k]) begin
                level_mem[k] = '0;
                count_mem[k] = '0;
            end
            frame_acc = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic [mgpa_pkg::CFG_IDX_W-1:0] idx,
                              logic [mgpa_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mgpa_pkg::REG_CELL_W:   cell_w      = data[mgpa_pkg::DIM_W-1:0];
                mgpa_pkg::REG_CELL_H:   cell_h      = data[mgpa_pkg::DIM_W-1:0];
                mgpa_pkg::REG_HISTORY:  history     = data[mgpa_pkg::HIST_W-1:0];
                mgpa_pkg::REG_DURATION: duration    = data[mgpa_pkg::COUNT_W-1:0];
                mgpa_pkg::REG_LEFT:     left_bound  = data[mgpa_pkg::BOUND_W-1:0];
                mgpa_pkg::REG_RIGHT:    right_bound = data[mgpa_pkg::BOUND_W-1:0];
                mgpa_pkg::REG_UPPER:    upper_bound = data[mgpa_pkg::BOUND_W-1:0];
                mgpa_pkg::REG_LOWER:    lower_bound = data[mgpa_pkg::BOUND_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_cell(logic [mgpa_pkg::ROW_W-1:0] row,
                                logic [mgpa_pkg::COL_W-1:0] col,
                                logic [mgpa_pkg::MOTION_W-1:0] motion);
            t_grid_result r;
            int unsigned  slot, cap, thr, lvl, cnt, cx, cy;
            r = '0;
            if (row >= GRID || col >= GRID) begin
                r.frame_alarm = frame_acc;
            end else begin
                slot = row * GRID + col;
                cap  = 32'(cell_w) * 32'(history);
                if (cap > mgpa_pkg::LEVEL_MAX) cap = mgpa_pkg::LEVEL_MAX;
                thr = cap / 4;
                lvl = 32'(level_mem[slot]) + 32'(motion);
                if (lvl > cap) lvl = cap;
                cnt = 32'(count_mem[slot]);
                if (lvl >= thr) begin
                    if (cnt < mgpa_pkg::COUNT_MAX) cnt++;
                end else begin
                    cnt = 0;
                end
                count_mem[slot] = cnt[mgpa_pkg::COUNT_W-1:0];
                cx = 32'(col) * 32'(cell_w) + 32'(cell_w) / 2;
                cy = 32'(row) * 32'(cell_h) + 32'(cell_h) / 2;
                r.in_window   = (cx >= left_bound && cx <= right_bound &&
                                 cy >= upper_bound && cy <= lower_bound);
                r.cell_alarm  = r.in_window && (cnt >= duration);
                frame_acc     = frame_acc | r.cell_alarm;
                r.frame_alarm = frame_acc;
                r.last_cell   = (row == GRID - 1) && (col == GRID - 1);
                r.level       = lvl[mgpa_pkg::LEVEL_W-1:0];
                r.count       = cnt[mgpa_pkg::COUNT_W-1:0];
                // leak after the result is formed
                level_mem[slot] = (lvl > cell_w) ? mgpa_pkg::LEVEL_W'(lvl - cell_w) : '0;
                if (r.last_cell) frame_acc = 1'b0;
            end
            pending = {pending, r};
        endfunction

        function void note_field(string name, int unsigned want, int unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        endfunction

        function void check_result(t_grid_result got);
            t_grid_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual level %0d count %0d",
                         $time, got.level, got.count);
                return;
            end
            want = pending.pop_front();
            if (got.level != want.level)
                note_field("cell_level", want.level, got.level);
            if (got.count != want.count)
                note_field("cell_count", want.count, got.count);
            if (got.in_window != want.in_window)
                note_field("in_window", want.in_window, got.in_window);
            if (got.cell_alarm != want.cell_alarm)
                note_field("cell_alarm", want.cell_alarm, got.cell_alarm);
            if (got.frame_alarm != want.frame_alarm)
                note_field("frame_alarm", want.frame_alarm, got.frame_alarm);
            if (got.last_cell != want.last_cell)
                note_field("last_cell", want.last_cell, got.last_cell);
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [mgpa_pkg::ROW_W-1:0]      i_cell_row;
    logic [mgpa_pkg::COL_W-1:0]      i_cell_col;
    logic [mgpa_pkg::MOTION_W-1:0]   i_motion_count;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [mgpa_pkg::LEVEL_W-1:0]    o_cell_level;
    logic [mgpa_pkg::COUNT_W-1:0]    o_cell_count;
    logic                            o_in_window;
    logic                            o_cell_alarm;
    logic                            o_frame_alarm;
    logic                            o_last_cell;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [mgpa_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mgpa_pkg::CFG_DATA_W-1:0] i_cfg_data;

    t_grid_alarm_ledger              ledger;
    // register values for the next phase
    logic [mgpa_pkg::CFG_DATA_W-1:0] reg_plan [1 << mgpa_pkg::CFG_IDX_W];
    bit                              idle_on;     // random gaps/stalls enabled for this stretch
    bit                              hold_req;    // ask the receiver for one long hold-off
    int                              items_sent;
    int                              quiet_cycles;

    motion_grid_persistence_alarm #(
        .GRID_SPLIT(GRID)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_motion_count (i_motion_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cell_level   (o_cell_level),
        .o_cell_count   (o_cell_count),
        .o_in_window    (o_in_window),
        .o_cell_alarm   (o_cell_alarm),
        .o_frame_alarm  (o_frame_alarm),
        .o_last_cell    (o_last_cell),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample every channel at the rising edge; outputs still hold pre-edge values here.
    always @(posedge i_clk) begin : monitor
        t_grid_result seen;
        bit           moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                ledger.set_reg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                ledger.take_cell(i_cell_row, i_cell_col, i_motion_count);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                seen.level       = o_cell_level;
                seen.count       = o_cell_count;
                seen.in_window   = o_in_window;
                seen.cell_alarm  = o_cell_alarm;
                seen.frame_alarm = o_frame_alarm;
                seen.last_cell   = o_last_cell;
                ledger.check_result(seen);
                moved = 1'b1;
            end
            // watchdog: nothing moved for too long means a hang
            if (moved) begin
                quiet_cycles = 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // Result side: random stall before each transfer while gaps are enabled, one long hold-off on request.
    initial begin : result_sink
        int hold;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = idle_on ? $urandom_range(0, 9) : 0;
            if (hold_req) begin
                hold     = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Called and returns at a falling edge; valid stays high for a back-to-back transfer.
    task automatic send_cell(logic [mgpa_pkg::ROW_W-1:0] row, logic [mgpa_pkg::COL_W-1:0] col,
                             logic [mgpa_pkg::MOTION_W-1:0] motion);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cell_row     <= row;
        i_cell_col     <= col;
        i_motion_count <= motion;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Quiet the input and let every expected result drain out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (ledger.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [mgpa_pkg::CFG_IDX_W-1:0] idx,
                             logic [mgpa_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Every register gets written on each phase change.
    task automatic program_regs();
        wait_idle();
        for (int k = 0; k < (1 << mgpa_pkg::CFG_IDX_W); k++)
            write_reg(mgpa_pkg::CFG_IDX_W'(k), reg_plan[k]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic plan_fixed(logic [mgpa_pkg::CFG_DATA_W-1:0] bw,
                              logic [mgpa_pkg::CFG_DATA_W-1:0] bh,
                              logic [mgpa_pkg::CFG_DATA_W-1:0] hist,
                              logic [mgpa_pkg::CFG_DATA_W-1:0] dur,
                              logic [mgpa_pkg::CFG_DATA_W-1:0] lft,
                              logic [mgpa_pkg::CFG_DATA_W-1:0] rgt,
                              logic [mgpa_pkg::CFG_DATA_W-1:0] upr,
                              logic [mgpa_pkg::CFG_DATA_W-1:0] lwr);
        reg_plan[mgpa_pkg::REG_CELL_W]   = bw;
        reg_plan[mgpa_pkg::REG_CELL_H]   = bh;
        reg_plan[mgpa_pkg::REG_HISTORY]  = hist;
        reg_plan[mgpa_pkg::REG_DURATION] = dur;
        reg_plan[mgpa_pkg::REG_LEFT]     = lft;
        reg_plan[mgpa_pkg::REG_RIGHT]    = rgt;
        reg_plan[mgpa_pkg::REG_UPPER]    = upr;
        reg_plan[mgpa_pkg::REG_LOWER]    = lwr;
    endtask

    // Mostly modest sizes and short durations so alarms happen; now and then raw 16-bit data.
    task automatic plan_random();
        int unsigned lft, upr;
        lft = $urandom_range(0, 400);
        upr = $urandom_range(0, 300);
        plan_fixed(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 120)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 90)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8)),
                   ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                   16'(lft), 16'(lft + $urandom_range(0, 2047 - lft)),
                   16'(upr), 16'(upr + $urandom_range(0, 2047 - upr)));
        if ($urandom_range(0, 3) == 0) begin
            reg_plan[mgpa_pkg::REG_LEFT]  = 16'($urandom);
            reg_plan[mgpa_pkg::REG_RIGHT] = 16'($urandom);
            reg_plan[mgpa_pkg::REG_UPPER] = 16'($urandom);
            reg_plan[mgpa_pkg::REG_LOWER] = 16'($urandom);
        end
    endtask

    // Counts mostly near the level threshold, with zeros and full-range values mixed in.
    function automatic logic [mgpa_pkg::MOTION_W-1:0] pick_motion(int unsigned cap,
                                                                  int unsigned bw);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return mgpa_pkg::MOTION_W'($urandom_range(0, (1 << mgpa_pkg::MOTION_W) - 1));
            2:       return MOTION_ALL;
            default: return mgpa_pkg::MOTION_W'($urandom_range(0, cap / 3 + 2 * bw + 1));
        endcase
    endfunction

    // Raster frames, sometimes cut short, each followed by a few stray or off-grid cells.
    task automatic run_frames(int frames);
        int unsigned bw, cap, stop;
        bw  = reg_plan[mgpa_pkg::REG_CELL_W][mgpa_pkg::DIM_W-1:0];
        cap = bw * reg_plan[mgpa_pkg::REG_HISTORY][mgpa_pkg::HIST_W-1:0];
        if (cap > mgpa_pkg::LEVEL_MAX) cap = mgpa_pkg::LEVEL_MAX;
        repeat (frames) begin
            stop = ($urandom_range(0, 4) == 0) ? $urandom_range(1, GRID*GRID - 1) : GRID*GRID;
            for (int k = 0; k < stop; k++)
                send_cell(mgpa_pkg::ROW_W'(k / GRID), mgpa_pkg::COL_W'(k % GRID),
                          pick_motion(cap, bw));
            repeat ($urandom_range(0, 6))
                send_cell(mgpa_pkg::ROW_W'($urandom_range(0, 15)),
                          mgpa_pkg::COL_W'($urandom_range(0, 15)),
                          pick_motion(cap, bw));
        end
    endtask

    initial begin : stimulus
        ledger         = new();
        idle_on        = 1'b0;
        hold_req       = 1'b0;
        items_sent     = 0;
        quiet_cycles   = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cell_row     = '0;
        i_cell_col     = '0;
        i_motion_count = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset config (cap 400, threshold 100, whole grid in window).
        send_cell(4'd0, 4'd0, '0);
        send_cell(4'd0, 4'd0, MOTION_ALL);         // level saturates at cap
        send_cell(4'd0, 4'd0, '0);                 // leaked level still above threshold
        send_cell(4'd0, 4'd1, 21'd99);             // just under threshold
        send_cell(4'd0, 4'd1, 21'd1);
        send_cell(4'd0, 4'd2, 21'd100);            // exactly threshold
        send_cell(4'd9, 4'd9, 21'd5);              // last cell ends the frame
        send_cell(4'd15, 4'd15, MOTION_ALL);       // off grid: no state change
        send_cell(4'd10, 4'd0, 21'd7);
        send_cell(4'd0, 4'd10, 21'd7);
        send_cell(4'd10, 4'd5, 21'd3);
        send_cell(4'd5, 4'd10, 21'd3);
        send_cell(4'd9, 4'd0, 21'd400);
        send_cell(4'd0, 4'd9, 21'd401);
        send_cell(4'd5, 4'd5, 21'd12345);          // out of raster order
        send_cell(4'd3, 4'd7, 21'h0AAAAA);
        send_cell(4'd9, 4'd9, '0);
        send_cell(4'd15, 4'd0, 21'h155555);

        for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
            case (phase)
                // wide cap overflows the level width; every in-window cell alarms
                0: plan_fixed(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,
                              16'd0, 16'd2047, 16'd0, 16'd2047);
                // zero cell width: zero cap, counter runs on every cell
                1: plan_fixed(16'd0, 16'd1, 16'd64, 16'd2,
                              16'd0, 16'd2047, 16'd0, 16'd2047);
                // zero history, empty window, largest duration
                2: plan_fixed(16'd1024, 16'd1024, 16'd0, 16'hFFFF,
                              16'd2047, 16'd0, 16'd2047, 16'd0);
                // unit cell with a tiny window
                3: plan_fixed(16'd1, 16'd1, 16'd1, 16'd1,
                              16'd0, 16'd5, 16'd3, 16'd6);
                default: plan_random();
            endcase
            program_regs();
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 0) begin
                // off-grid cell while the frame alarm is set mid-frame
                send_cell(4'd0, 4'd0, 21'd1);
                send_cell(4'd12, 4'd3, '0);
            end
            if (phase == 5) begin
                // long receiver hold-off while cells keep coming: fills the pipe
                idle_on  = 1'b0;
                hold_req = 1'b1;
            end
            run_frames($urandom_range(1, 2));
        end

        wait_idle();
        if (ledger.errors == 0 && ledger.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
